// ===== design/text_line_justifier_top_assert.svh =====
// Assertion macros for the text line justifier top level.
// Needs clk and rst_n in the scope of each use; no other dependencies.
`ifndef TEXT_LINE_JUSTIFIER_TOP_ASSERT_SVH
`define TEXT_LINE_JUSTIFIER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// condition holds at every clock edge out of reset
`define TLJ_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tlj: invariant violated");
// antecedent implies consequent in the same cycle
`define TLJ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlj: implication violated");
// antecedent implies consequent in the next cycle
`define TLJ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlj: next-cycle implication violated");
`else
`define TLJ_ASSERT(lbl, cond)
`define TLJ_ASSERT_IMP(lbl, ante, cons)
`define TLJ_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== design/tlj_pkg.sv =====
// Shared constants and interface structs for the text line justifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package tlj_pkg;

  localparam int MAX_WIDTH = 64;
  localparam int MAX_WORDS = 32;

  localparam int LEN_W  = 7;
  localparam int GAP_W  = 7;
  localparam int CNT_W  = $clog2(MAX_WORDS + 1);
  localparam int IDX_W  = $clog2(MAX_WORDS);
  localparam int DIV_W  = GAP_W;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // APB register map: one word register per 4-byte slot
  localparam int APB_DW  = 32;
  localparam int PADDR_W = 3;
  localparam logic REG_LINE_WIDTH = 1'b0;   // word index paddr[2]
  localparam logic [LEN_W-1:0] LINE_WIDTH_RST = LEN_W'(64);

  // divider request / response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [IDX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [IDX_W-1:0] rem;
  } div_rsp_t;

  // line buffer access
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [LEN_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
  } buf_req_t;

endpackage

`default_nettype wire

// ===== design/tlj_div.sv =====
// Restoring divider, one quotient bit per cycle, for slack over inner gaps.
// Depends on tlj_pkg.
`default_nettype none

module tlj_div
  import tlj_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [IDX_W-1:0]  acc_r, acc_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [IDX_W-1:0]  dvs_r, dvs_nxt;

  logic [IDX_W:0]    partial;
  logic [IDX_W:0]    diff;
  logic              ge;

  // one shift-subtract step
  assign partial = {acc_r, quo_r[DIV_W-1]};
  assign ge      = partial >= {1'b0, dvs_r};
  assign diff    = partial - {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (req.start) begin
      cnt_nxt = DCNT_W'(DIV_W);
      acc_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = req.divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - DCNT_W'(1);
      acc_nxt  = ge ? diff[IDX_W-1:0] : partial[IDX_W-1:0];
      quo_nxt  = {quo_r[DIV_W-2:0], ge};
      done_nxt = (cnt_r == DCNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = acc_r;

endmodule

`default_nettype wire

// ===== design/tlj_linebuf.sv =====
// Word length buffer for the line being built: one write, one registered read.
// Depends on tlj_pkg.
`default_nettype none

module tlj_linebuf
  import tlj_pkg::*;
(
  input  wire logic             clk,
  input  wire buf_req_t         req,
  output logic [LEN_W-1:0]      rd_data
);

  logic [LEN_W-1:0] mem [MAX_WORDS];
  logic [LEN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/text_line_justifier_top.sv =====
// Text line justifier top level: APB register, sequencer, output register.
// Depends on tlj_pkg, tlj_div, tlj_linebuf and text_line_justifier_top_assert.svh.
//
// Use: word lengths are offered on in_word_len / in_final_word and transfer
// when start is high while busy is low. Words collect in a line buffer; a
// line is placed when the next word does not fit, when it is exactly full,
// when it holds the maximum word count, or at the final word. Each placed
// word comes out as one transfer on out_* marked by out_valid for a single
// cycle; the receiver cannot stall, so every result must be taken then.
// line_width sits at APB address 0; the user must write it only while idle,
// as the block itself does not enforce this. Per input, a word that is only
// buffered passes through the append state; a flushed line passes through a
// setup state, then the shared bit-serial divider when it is fully justified
// with two or more words, then a read of each word out of the buffer; a
// too-long word adds its own state. Results are registered before they
// appear on out_*.
// Reset (synchronous, rst_n low) empties the line and sets line_width to 64;
// the buffer contents are not cleared and are never read before written.
`default_nettype none

`include "text_line_justifier_top_assert.svh"

module text_line_justifier_top
  import tlj_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [LEN_W-1:0]   in_word_len,
  input  wire logic               in_final_word,
  // result channel
  output logic                    out_valid,
  output logic [LEN_W-1:0]        out_len,
  output logic [GAP_W-1:0]        out_gap_after,
  output logic                    out_line_end,
  output logic                    out_too_long,
  output logic                    out_run_last,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FLUSH  = 6'b000010,
    S_DIV    = 6'b000100,
    S_EMIT   = 6'b001000,
    S_LONG   = 6'b010000,
    S_APPEND = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] line_width_r;
  logic [LEN_W-1:0] chars_r, chars_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             pre_r, pre_nxt;     // flush ahead of the new word
  logic             left_r, left_nxt;   // left-justified flush
  logic             more_r, more_nxt;   // results follow this flush
  logic             long_r, long_nxt;
  logic             fin_r, fin_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] w_r, w_nxt;
  logic [GAP_W-1:0] slack_r, slack_nxt;

  logic             ov_r, ov_nxt;
  logic [LEN_W-1:0] olen_r, olen_nxt;
  logic [GAP_W-1:0] ogap_r, ogap_nxt;
  logic             oend_r, oend_nxt;
  logic             otl_r, otl_nxt;
  logic             olast_r, olast_nxt;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  buf_req_t         buf_req;
  logic [LEN_W-1:0] rd_len;

  logic             accept;
  logic             cfg_wr;
  logic [LEN_W-1:0] w_eff;
  logic             is_long;
  logic [LEN_W:0]   topad;
  logic [LEN_W:0]   fit_sum;
  logic             no_fit;
  logic [LEN_W-1:0] app_chars;
  logic [CNT_W-1:0] app_held;
  logic             last_word;
  logic             uniform;
  logic             extra;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
    end else if (cfg_wr && (paddr[2] == REG_LINE_WIDTH)) begin
      line_width_r <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LINE_WIDTH) ?
                  {{(APB_DW-LEN_W){1'b0}}, line_width_r} : '0;

  // ------------------------------------------------ input decode (idle)
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // width clamp: 0 acts as 1, above the maximum acts as the maximum
  always_comb begin
    if (line_width_r == '0) begin
      w_eff = LEN_W'(1);
    end else if (line_width_r > LEN_W'(MAX_WIDTH)) begin
      w_eff = LEN_W'(MAX_WIDTH);
    end else begin
      w_eff = line_width_r;
    end
  end

  assign is_long = in_word_len > w_eff;
  assign topad   = {1'b0, in_word_len} + {{LEN_W{1'b0}}, (held_r != '0)};
  assign fit_sum = {1'b0, chars_r} + topad;
  assign no_fit  = fit_sum > {1'b0, w_eff};

  // ---------------------------------------------------- append values
  assign app_chars = LEN_W'({1'b0, chars_r} + {1'b0, len_r}
                            + {{LEN_W{1'b0}}, (held_r != '0)});
  assign app_held  = held_r + CNT_W'(1);

  // ------------------------------------------------------- emit values
  assign last_word = ({{(CNT_W-IDX_W){1'b0}}, idx_r} == (held_r - CNT_W'(1)));
  assign uniform   = left_r || (held_r == CNT_W'(1));
  assign extra     = {{(DIV_W-IDX_W){1'b0}}, idx_r} < {{(DIV_W-IDX_W){1'b0}}, div_rsp.rem};

  // --------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    chars_nxt = chars_r;
    held_nxt  = held_r;
    idx_nxt   = '0;
    pre_nxt   = pre_r;
    left_nxt  = left_r;
    more_nxt  = more_r;
    long_nxt  = long_r;
    fin_nxt   = fin_r;
    len_nxt   = len_r;
    w_nxt     = w_r;
    slack_nxt = slack_r;

    ov_nxt    = 1'b0;
    olen_nxt  = olen_r;
    ogap_nxt  = ogap_r;
    oend_nxt  = oend_r;
    otl_nxt   = otl_r;
    olast_nxt = olast_r;

    div_req.start    = 1'b0;
    div_req.dividend = (chars_r < w_r) ? DIV_W'(w_r - chars_r) : '0;
    div_req.divisor  = IDX_W'(held_r - CNT_W'(1));

    buf_req.wr_en    = 1'b0;
    buf_req.wr_addr  = held_r[IDX_W-1:0];
    buf_req.wr_data  = len_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          len_nxt  = in_word_len;
          fin_nxt  = in_final_word;
          w_nxt    = w_eff;
          long_nxt = is_long;
          if ((held_r != '0) && (is_long || no_fit)) begin
            // buffered line goes out justified before the new word
            pre_nxt   = 1'b1;
            left_nxt  = 1'b0;
            more_nxt  = is_long || in_final_word || (in_word_len == w_eff);
            state_nxt = S_FLUSH;
          end else if (is_long) begin
            state_nxt = S_LONG;
          end else begin
            state_nxt = S_APPEND;
          end
        end
      end

      S_APPEND: begin
        buf_req.wr_en = 1'b1;
        chars_nxt     = app_chars;
        held_nxt      = app_held;
        if (fin_r || (app_chars == w_r) || (app_held >= CNT_W'(MAX_WORDS))) begin
          pre_nxt   = 1'b0;
          left_nxt  = fin_r;
          more_nxt  = 1'b0;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_FLUSH: begin
        slack_nxt = div_req.dividend;
        if (!uniform) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        ov_nxt    = 1'b1;
        olen_nxt  = rd_len;
        oend_nxt  = last_word;
        otl_nxt   = 1'b0;
        olast_nxt = last_word && !more_r;
        if (last_word) begin
          ogap_nxt = uniform ? slack_r : '0;
        end else if (uniform) begin
          ogap_nxt = GAP_W'(1);
        end else begin
          ogap_nxt = GAP_W'(1) + div_rsp.quo + {{(GAP_W-1){1'b0}}, extra};
        end
        if (last_word) begin
          held_nxt = '0;
          chars_nxt = '0;
          if (!pre_r) begin
            state_nxt = S_IDLE;
          end else if (long_r) begin
            state_nxt = S_LONG;
          end else begin
            state_nxt = S_APPEND;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_LONG: begin
        ov_nxt    = 1'b1;
        olen_nxt  = len_r;
        ogap_nxt  = '0;
        oend_nxt  = 1'b1;
        otl_nxt   = 1'b1;
        olast_nxt = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // read the word needed next cycle
    buf_req.rd_addr = idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chars_r <= '0;
      held_r  <= '0;
      idx_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chars_r <= chars_nxt;
      held_r  <= held_nxt;
      idx_r   <= idx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // per-item and result payload, no reset
  always_ff @(posedge clk) begin
    pre_r   <= pre_nxt;
    left_r  <= left_nxt;
    more_r  <= more_nxt;
    long_r  <= long_nxt;
    fin_r   <= fin_nxt;
    len_r   <= len_nxt;
    w_r     <= w_nxt;
    slack_r <= slack_nxt;
    olen_r  <= olen_nxt;
    ogap_r  <= ogap_nxt;
    oend_r  <= oend_nxt;
    otl_r   <= otl_nxt;
    olast_r <= olast_nxt;
  end

  // ----------------------------------------------------- sub-units
  tlj_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  tlj_linebuf u_buf (
    .clk     (clk),
    .req     (buf_req),
    .rd_data (rd_len)
  );

  // ------------------------------------------------------- outputs
  assign out_valid     = ov_r;
  assign out_len       = olen_r;
  assign out_gap_after = ogap_r;
  assign out_line_end  = oend_r;
  assign out_too_long  = otl_r;
  assign out_run_last  = olast_r;

  // ---------------------------------------------------- assertions
  `TLJ_ASSERT_NXT(a_accept_busy, accept, busy)
  `TLJ_ASSERT_IMP(a_long_alone, out_valid && out_too_long,
                  out_line_end && out_run_last && (out_gap_after == '0))
  `TLJ_ASSERT_IMP(a_last_ends_line, out_valid && out_run_last, out_line_end)
  `TLJ_ASSERT_IMP(a_idle_room, state_r == S_IDLE, held_r < CNT_W'(MAX_WORDS))

endmodule

`default_nettype wire
